// File: sv/saaw_pkg.sv
// Shared types and constants for the surfel angle agreement weight block.
package saaw_pkg;

  localparam int FRAC_BITS = 14;
  localparam int XSHIFT    = 2 * FRAC_BITS - 16;
  localparam int DOT_W     = 34;
  localparam int SQ_STAGES = 17;
  localparam int LANE_LAT  = 25;

  localparam logic [DOT_W-1:0] DOT_ONE = DOT_W'(1) << (2 * FRAC_BITS);

  localparam logic [18:0] POLY_K3 = 19'd314226;
  localparam logic [20:0] POLY_C2 = 21'd1245893;
  localparam logic [21:0] POLY_C1 = 22'd3558689;
  localparam logic [25:0] POLY_C0 = 26'd26352456;
  localparam logic [25:0] PI_Q24  = 26'd52707179;
  localparam logic [25:0] EXP_KS  = 26'd54396396;
  localparam logic [17:0] MIN_EXP = 18'd8192;
  localparam logic [14:0] LOW_W   = 15'd2048;
  localparam logic [17:0] ADD_W   = 18'd20480;
  localparam logic [14:0] MIN_HI_W = 15'd12288;

  typedef logic signed [15:0] comp_t;
  typedef logic [14:0] weight_t;

  typedef struct packed {
    comp_t scene_normal_x;
    comp_t scene_normal_y;
    comp_t scene_normal_z;
    comp_t model_normal_x;
    comp_t model_normal_y;
    comp_t model_normal_z;
    comp_t scene_view_x;
    comp_t scene_view_y;
    comp_t scene_view_z;
    comp_t model_view_x;
    comp_t model_view_y;
    comp_t model_view_z;
  } pair_t;

  typedef struct packed {
    weight_t normal_weight;
    weight_t view_weight;
  } weights_t;

endpackage

// File: sv/saaw_if.sv
// Valid/ready channel interfaces for surfel pairs and weight results.
interface saaw_pair_if;
  import saaw_pkg::*;
  logic  valid;
  logic  ready;
  pair_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface saaw_weight_if;
  import saaw_pkg::*;
  logic     valid;
  logic     ready;
  weights_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/saaw_lane.sv
// One angle lane: dot product, clamp, polynomial arccos, gaussian weight.
module saaw_lane (
  input  logic              clk,
  input  logic              en,
  input  saaw_pkg::comp_t   a [3],
  input  saaw_pkg::comp_t   b [3],
  output saaw_pkg::weight_t weight
);
  import saaw_pkg::*;

  logic signed [31:0]    prod [3];
  logic signed [DOT_W-1:0] dot;
  logic [16:0] x3, x4, x5;
  logic        neg3;
  logic [35:0] pk;
  logic [37:0] p2;
  logic [38:0] p3;
  logic [25:0] t7;
  logic [25:0] tdl [13];
  logic [33:0] sv [SQ_STAGES];
  logic [33:0] sr [SQ_STAGES];
  logic        nd [18];
  logic [25:0] a21, ang22;
  logic [51:0] sq23;
  logic [53:0] pe24;

  logic signed [DOT_W-1:0] dot_cl;
  logic [DOT_W-1:0] mag;
  logic [DOT_W-1:0] xr;
  logic [20:0] t1;
  logic [21:0] t2;
  logic [41:0] ts;
  logic [17:0] e25;
  logic [33:0] sq_v [SQ_STAGES];
  logic [33:0] sq_r [SQ_STAGES];

  always_comb begin
    if (dot > $signed(DOT_ONE)) begin
      dot_cl = $signed(DOT_ONE);
    end else if (dot < -$signed(DOT_ONE)) begin
      dot_cl = -$signed(DOT_ONE);
    end else begin
      dot_cl = dot;
    end
    mag = dot_cl[DOT_W-1] ? DOT_W'(-dot_cl) : DOT_W'(dot_cl);
    xr  = (mag + (DOT_W'(1) << (XSHIFT - 1))) >> XSHIFT;
    t1  = POLY_C2 - 21'(pk >> 16);
    t2  = POLY_C1 - 22'(p2 >> 16);
    ts  = 42'(tdl[12]) * 42'(sr[SQ_STAGES-1][16:0]);
    e25 = 18'(pe24 >> 36);
  end

  // restoring square root, one result bit per stage
  always_comb begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      logic [33:0] vin, rin, trial;
      vin = (k == 0) ? (34'(17'd65536 - x3) << 16) : sv[(k == 0) ? 0 : k - 1];
      rin = (k == 0) ? 34'd0 : sr[(k == 0) ? 0 : k - 1];
      trial = rin + (34'd1 << (32 - 2 * k));
      if (vin >= trial) begin
        sq_v[k] = vin - trial;
        sq_r[k] = (rin >> 1) + (34'd1 << (32 - 2 * k));
      end else begin
        sq_v[k] = vin;
        sq_r[k] = rin >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod[i] <= 32'(a[i]) * 32'(b[i]);
      end
      dot  <= DOT_W'(prod[0]) + DOT_W'(prod[1]) + DOT_W'(prod[2]);
      x3   <= 17'(xr);
      neg3 <= dot_cl[DOT_W-1];
      x4   <= x3;
      x5   <= x4;
      pk   <= 36'(POLY_K3) * 36'(x3);
      p2   <= 38'(t1) * 38'(x4);
      p3   <= 39'(t2) * 39'(x5);
      t7   <= POLY_C0 - 26'(p3 >> 16);
      tdl[0] <= t7;
      for (int i = 1; i < 13; i++) begin
        tdl[i] <= tdl[i-1];
      end
      for (int k = 0; k < SQ_STAGES; k++) begin
        sv[k] <= sq_v[k];
        sr[k] <= sq_r[k];
      end
      nd[0] <= neg3;
      for (int i = 1; i < 18; i++) begin
        nd[i] <= nd[i-1];
      end
      a21   <= 26'(ts >> 16);
      ang22 <= nd[17] ? PI_Q24 - a21 : a21;
      sq23  <= 52'(ang22) * 52'(ang22);
      pe24  <= 54'(sq23 >> 24) * 54'(EXP_KS);
      weight <= (e25 > MIN_EXP) ? LOW_W : 15'(ADD_W - e25);
    end
  end

endmodule

// File: sv/surfel_angle_agreement_weight.sv
// A pair passes 25 lane stages (17 in the pipelined sqrt unit), then the output register.
// Throughput: one pair per cycle unless stalled; each sqrt stage gives one result bit.
// The whole pipe advances together whenever the output register is empty or taken.
// Reset (rst, synchronous): clears all stage valid bits and the output valid.
// No configuration; no stored state between pairs.
module surfel_angle_agreement_weight (
  input logic          clk,
  input logic          rst,
  saaw_pair_if.sink    pair_in,
  saaw_weight_if.source weight_out
);
  import saaw_pkg::*;

  logic    en;
  logic    vld [LANE_LAT];
  weight_t w_normal, w_view;
  comp_t   na [3], nb [3], va [3], vb [3];

  assign en = !weight_out.valid || weight_out.ready;
  assign pair_in.ready = en;

  assign na[0] = pair_in.data.scene_normal_x;
  assign na[1] = pair_in.data.scene_normal_y;
  assign na[2] = pair_in.data.scene_normal_z;
  assign nb[0] = pair_in.data.model_normal_x;
  assign nb[1] = pair_in.data.model_normal_y;
  assign nb[2] = pair_in.data.model_normal_z;
  assign va[0] = pair_in.data.scene_view_x;
  assign va[1] = pair_in.data.scene_view_y;
  assign va[2] = pair_in.data.scene_view_z;
  assign vb[0] = pair_in.data.model_view_x;
  assign vb[1] = pair_in.data.model_view_y;
  assign vb[2] = pair_in.data.model_view_z;

  saaw_lane u_normal (.clk(clk), .en(en), .a(na), .b(nb), .weight(w_normal));
  saaw_lane u_view   (.clk(clk), .en(en), .a(va), .b(vb), .weight(w_view));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        vld[i] <= 1'b0;
      end
      weight_out.valid <= 1'b0;
    end else if (en) begin
      vld[0] <= pair_in.valid;
      for (int i = 1; i < LANE_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
      weight_out.valid <= vld[LANE_LAT-1];
    end
  end

  // merge: both lane weights land in one result register
  always_ff @(posedge clk) begin
    if (en) begin
      weight_out.data.normal_weight <= w_normal;
      weight_out.data.view_weight   <= w_view;
    end
  end

  a_rst_clears: assert property (@(posedge clk) rst |=> !weight_out.valid)
    else $error("output valid after reset");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    weight_out.valid |-> (weight_out.data.normal_weight == LOW_W ||
      (weight_out.data.normal_weight >= MIN_HI_W &&
       weight_out.data.normal_weight <= 15'(ADD_W))))
    else $error("normal weight out of range");

  a_view_range: assert property (@(posedge clk) disable iff (rst)
    weight_out.valid |-> (weight_out.data.view_weight == LOW_W ||
      (weight_out.data.view_weight >= MIN_HI_W &&
       weight_out.data.view_weight <= 15'(ADD_W))))
    else $error("view weight out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld[LANE_LAT-1]) && $stable(vld[0]))
    else $error("pipe moved while stalled");

endmodule
